FILE: rtl/csss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_pkg: shared types and constants of the sampled-signal statistics block
// Item classification record, configuration record, register and
// statistic indexes.
// ----------------------------------------------------------------------------
package csss_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_LIMIT_EN = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;

  localparam int unsigned CFG_DATA_W  = 31;
  localparam logic [30:0] LIMIT_RESET = 31'd1000000;
  localparam logic [6:0]  WIDTH_RESET = 7'd1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_STATS   = 19;
  localparam int unsigned STAT_W      = 64;
  localparam int unsigned TIME_W      = 64;

  typedef enum logic [4:0] {
    ST_SAMPLES     = 5'd0,
    ST_KNOWN       = 5'd1,
    ST_UNKNOWN     = 5'd2,
    ST_TRANSITIONS = 5'd3,
    ST_TRUNCATED   = 5'd4,
    ST_KNOWN_SEEN  = 5'd5,
    ST_FIRST       = 5'd6,
    ST_FINAL       = 5'd7,
    ST_MIN         = 5'd8,
    ST_MAX         = 5'd9,
    ST_LOW         = 5'd10,
    ST_HIGH        = 5'd11,
    ST_BURSTS      = 5'd12,
    ST_MAX_RUN     = 5'd13,
    ST_CHG_FIRST   = 5'd14,
    ST_CHG_LAST    = 5'd15,
    ST_HIGH_FIRST  = 5'd16,
    ST_HIGH_LAST   = 5'd17,
    ST_FALL_LAST   = 5'd18
  } stat_idx_e;

  typedef struct packed {
    logic        limit_en;
    logic [30:0] limit;
    logic [6:0]  width;
  } cfg_t;

  // classified item as it travels from front to back (value travels beside it)
  typedef struct packed {
    logic              is_end;
    logic              unknown;
    logic              is_zero;
    logic              is_high;
    logic [TIME_W-1:0] stamp;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/csss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_front: configuration registers and sample classification
// Masks the value to the configured width and tags it zero / high.
// ----------------------------------------------------------------------------
module csss_front #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [csss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           push_i,
  input  wire logic                           full_i,
  input  wire logic                           req_type_i,
  input  wire logic [VALUE_WIDTH-1:0]         sample_value_i,
  input  wire logic                           sample_unknown_i,
  input  wire logic [csss_pkg::TIME_W-1:0]    sample_time_i,
  output csss_pkg::cfg_t                      cfg_o,
  output logic                                wr_en_o,
  output csss_pkg::item_t                     wr_item_o,
  output logic [VALUE_WIDTH-1:0]              wr_value_o
);

  csss_pkg::cfg_t         cfg_q;
  logic [6:0]             w_eff;
  logic [VALUE_WIDTH-1:0] mask;
  logic [VALUE_WIDTH-1:0] value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_en <= 1'b1;
      cfg_q.limit    <= csss_pkg::LIMIT_RESET;
      cfg_q.width    <= csss_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csss_pkg::CFG_LIMIT_EN: cfg_q.limit_en <= cfg_wdata_i[0];
        csss_pkg::CFG_LIMIT:    cfg_q.limit    <= cfg_wdata_i[30:0];
        csss_pkg::CFG_WIDTH:    cfg_q.width    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // width 0 acts as 1, anything past the port width acts as the port width
  always_comb begin
    if (cfg_q.width == 7'd0) begin
      w_eff = 7'd1;
    end else if (cfg_q.width > 7'(VALUE_WIDTH)) begin
      w_eff = 7'(VALUE_WIDTH);
    end else begin
      w_eff = cfg_q.width;
    end
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      mask[i] = (7'(i) < w_eff);
    end
    value = sample_value_i & mask;
  end

  assign cfg_o              = cfg_q;
  assign wr_en_o            = push_i && !full_i;
  assign wr_value_o         = value;
  assign wr_item_o.is_end   = req_type_i;
  assign wr_item_o.unknown  = sample_unknown_i;
  assign wr_item_o.is_zero  = (value == '0);
  assign wr_item_o.is_high  = (value != '0) && (w_eff == 7'd1);
  assign wr_item_o.stamp    = sample_time_i;

endmodule
`default_nettype wire

FILE: rtl/csss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_queue: short FIFO between front and back
// Register array with read and write pointers; head is read combinationally.
// ----------------------------------------------------------------------------
module csss_queue #(
  parameter int unsigned WIDTH = 132
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned DEPTH = csss_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PTR_W+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

endmodule
`default_nettype wire

FILE: rtl/csss_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_stats: statistics engine
// Folds one sample per cycle into the counters until truncated; an end beat,
// taken once the report stage is idle, hands it the statistics and clears everything.
// ----------------------------------------------------------------------------
module csss_stats #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire csss_pkg::cfg_t          cfg_i,
  input  wire logic                    q_empty_i,
  input  wire csss_pkg::item_t         q_item_i,
  input  wire logic [VALUE_WIDTH-1:0]  q_value_i,
  output logic                         q_pop_o,
  input  wire logic                    rpt_busy_i,
  output logic                         rpt_load_o,
  output logic [csss_pkg::NUM_STATS-1:0][csss_pkg::STAT_W-1:0] stat_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 31) ? COUNT_WIDTH : 31;
  localparam int unsigned TW    = csss_pkg::TIME_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + 1'b1;
  endfunction

  cnt_t smp_cnt_q, known_cnt_q, unk_cnt_q, trans_cnt_q, low_cnt_q, high_cnt_q;
  cnt_t burst_cnt_q, run_len_q, longest_q;
  cnt_t smp_cnt_d, known_cnt_d, unk_cnt_d, trans_cnt_d, low_cnt_d, high_cnt_d;
  cnt_t burst_cnt_d, run_len_d, longest_d;
  val_t first_q, latest_q, min_q, max_q;
  val_t first_d, latest_d, min_d, max_d;
  logic [TW-1:0] chg_first_q, chg_last_q, hi_first_q, hi_last_q, fall_q;
  logic [TW-1:0] chg_first_d, chg_last_d, hi_first_d, hi_last_d, fall_d;
  logic known_seen_q, was_high_q, trunc_q;
  logic known_seen_d, was_high_d, trunc_d;

  logic smp_pop, end_pop;
  cnt_t cnt_inc, longest_fold;
  logic [TW-1:0] t;

  assign smp_pop    = !q_empty_i && !q_item_i.is_end;
  assign end_pop    = !q_empty_i && q_item_i.is_end && !rpt_busy_i;
  assign q_pop_o    = smp_pop || end_pop;
  assign rpt_load_o = end_pop;
  assign cnt_inc    = sat_inc(smp_cnt_q);
  assign t          = q_item_i.stamp;

  always_comb begin
    smp_cnt_d    = smp_cnt_q;
    known_cnt_d  = known_cnt_q;
    unk_cnt_d    = unk_cnt_q;
    trans_cnt_d  = trans_cnt_q;
    low_cnt_d    = low_cnt_q;
    high_cnt_d   = high_cnt_q;
    burst_cnt_d  = burst_cnt_q;
    run_len_d    = run_len_q;
    longest_d    = longest_q;
    first_d      = first_q;
    latest_d     = latest_q;
    min_d        = min_q;
    max_d        = max_q;
    chg_first_d  = chg_first_q;
    chg_last_d   = chg_last_q;
    hi_first_d   = hi_first_q;
    hi_last_d    = hi_last_q;
    fall_d       = fall_q;
    known_seen_d = known_seen_q;
    was_high_d   = was_high_q;
    trunc_d      = trunc_q;

    if (end_pop) begin
      smp_cnt_d    = '0;
      known_cnt_d  = '0;
      unk_cnt_d    = '0;
      trans_cnt_d  = '0;
      low_cnt_d    = '0;
      high_cnt_d   = '0;
      burst_cnt_d  = '0;
      run_len_d    = '0;
      longest_d    = '0;
      first_d      = '0;
      latest_d     = '0;
      min_d        = '0;
      max_d        = '0;
      chg_first_d  = '0;
      chg_last_d   = '0;
      hi_first_d   = '0;
      hi_last_d    = '0;
      fall_d       = '0;
      known_seen_d = 1'b0;
      was_high_d   = 1'b0;
      trunc_d      = 1'b0;
    end else if (smp_pop && !trunc_q) begin
      smp_cnt_d = cnt_inc;
      if (cfg_i.limit_en && (CMP_W'(cnt_inc) > CMP_W'(cfg_i.limit))) begin
        trunc_d = 1'b1;
      end else if (q_item_i.unknown) begin
        unk_cnt_d = sat_inc(unk_cnt_q);
        if (was_high_q) begin
          if (run_len_q > longest_q) longest_d = run_len_q;
          run_len_d  = '0;
          fall_d     = t;
          was_high_d = 1'b0;
        end
      end else begin
        known_cnt_d = sat_inc(known_cnt_q);
        if (q_item_i.is_zero) begin
          low_cnt_d = sat_inc(low_cnt_q);
        end else if (q_item_i.is_high) begin
          high_cnt_d = sat_inc(high_cnt_q);
        end
        if (q_item_i.is_high) begin
          if (!was_high_q) begin
            burst_cnt_d = sat_inc(burst_cnt_q);
            run_len_d   = COUNT_WIDTH'(1);
            if (hi_first_q == '0) hi_first_d = t;
          end else begin
            run_len_d = sat_inc(run_len_q);
          end
          hi_last_d  = t;
          was_high_d = 1'b1;
        end else if (was_high_q) begin
          if (run_len_q > longest_q) longest_d = run_len_q;
          run_len_d  = '0;
          fall_d     = t;
          was_high_d = 1'b0;
        end
        if (!known_seen_q) begin
          first_d      = q_value_i;
          latest_d     = q_value_i;
          min_d        = q_value_i;
          max_d        = q_value_i;
          known_seen_d = 1'b1;
        end else begin
          if (q_value_i != latest_q) begin
            trans_cnt_d = sat_inc(trans_cnt_q);
            if (chg_first_q == '0) chg_first_d = t;
            chg_last_d = t;
          end
          if (q_value_i < min_q) min_d = q_value_i;
          if (q_value_i > max_q) max_d = q_value_i;
          latest_d = q_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cnt_q    <= '0;
      known_cnt_q  <= '0;
      unk_cnt_q    <= '0;
      trans_cnt_q  <= '0;
      low_cnt_q    <= '0;
      high_cnt_q   <= '0;
      burst_cnt_q  <= '0;
      run_len_q    <= '0;
      longest_q    <= '0;
      first_q      <= '0;
      latest_q     <= '0;
      min_q        <= '0;
      max_q        <= '0;
      chg_first_q  <= '0;
      chg_last_q   <= '0;
      hi_first_q   <= '0;
      hi_last_q    <= '0;
      fall_q       <= '0;
      known_seen_q <= 1'b0;
      was_high_q   <= 1'b0;
      trunc_q      <= 1'b0;
    end else begin
      smp_cnt_q    <= smp_cnt_d;
      known_cnt_q  <= known_cnt_d;
      unk_cnt_q    <= unk_cnt_d;
      trans_cnt_q  <= trans_cnt_d;
      low_cnt_q    <= low_cnt_d;
      high_cnt_q   <= high_cnt_d;
      burst_cnt_q  <= burst_cnt_d;
      run_len_q    <= run_len_d;
      longest_q    <= longest_d;
      first_q      <= first_d;
      latest_q     <= latest_d;
      min_q        <= min_d;
      max_q        <= max_d;
      chg_first_q  <= chg_first_d;
      chg_last_q   <= chg_last_d;
      hi_first_q   <= hi_first_d;
      hi_last_q    <= hi_last_d;
      fall_q       <= fall_d;
      known_seen_q <= known_seen_d;
      was_high_q   <= was_high_d;
      trunc_q      <= trunc_d;
    end
  end

  // open high run counts toward the longest run in the report
  assign longest_fold = (was_high_q && (run_len_q > longest_q)) ? run_len_q : longest_q;

  always_comb begin
    stat_o = '0;
    stat_o[csss_pkg::ST_SAMPLES]     = 64'(smp_cnt_q);
    stat_o[csss_pkg::ST_KNOWN]       = 64'(known_cnt_q);
    stat_o[csss_pkg::ST_UNKNOWN]     = 64'(unk_cnt_q);
    stat_o[csss_pkg::ST_TRANSITIONS] = 64'(trans_cnt_q);
    stat_o[csss_pkg::ST_TRUNCATED]   = 64'(trunc_q);
    stat_o[csss_pkg::ST_KNOWN_SEEN]  = 64'(known_seen_q);
    stat_o[csss_pkg::ST_FIRST]       = 64'(first_q);
    stat_o[csss_pkg::ST_FINAL]       = 64'(latest_q);
    stat_o[csss_pkg::ST_MIN]         = 64'(min_q);
    stat_o[csss_pkg::ST_MAX]         = 64'(max_q);
    stat_o[csss_pkg::ST_LOW]         = 64'(low_cnt_q);
    stat_o[csss_pkg::ST_HIGH]        = 64'(high_cnt_q);
    stat_o[csss_pkg::ST_BURSTS]      = 64'(burst_cnt_q);
    stat_o[csss_pkg::ST_MAX_RUN]     = 64'(longest_fold);
    stat_o[csss_pkg::ST_CHG_FIRST]   = chg_first_q;
    stat_o[csss_pkg::ST_CHG_LAST]    = chg_last_q;
    stat_o[csss_pkg::ST_HIGH_FIRST]  = hi_first_q;
    stat_o[csss_pkg::ST_HIGH_LAST]   = hi_last_q;
    stat_o[csss_pkg::ST_FALL_LAST]   = fall_q;
  end

  a_trunc_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trunc_q && !end_pop) |=> trunc_q)
    else $error("truncated flag dropped without an end beat");

  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_pop |=> (smp_cnt_q == '0) && !known_seen_q && !was_high_q)
    else $error("state not cleared after end beat");

endmodule
`default_nettype wire

FILE: rtl/csss_report.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csss_report: report sequencer and result register
// Holds a snapshot of the statistics and emits them one beat per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module csss_report (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic [csss_pkg::NUM_STATS-1:0][csss_pkg::STAT_W-1:0] stat_i,
  output logic                         busy_o,
  input  wire logic                    pop_i,
  output logic                         empty_o,
  output logic [4:0]                   stat_index_o,
  output logic [csss_pkg::STAT_W-1:0]  stat_value_o,
  output logic                         last_stat_o
);

  logic [csss_pkg::NUM_STATS-1:0][csss_pkg::STAT_W-1:0] snap_q;
  logic                          busy_q;
  csss_pkg::stat_idx_e           idx_q;
  logic                          out_valid_q;
  logic [4:0]                    out_idx_q;
  logic [csss_pkg::STAT_W-1:0]   out_val_q;
  logic                          out_last_q;
  logic                          adv;

  assign adv = busy_q && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= stat_i;
    end
    if (adv) begin
      out_idx_q  <= idx_q;
      out_val_q  <= snap_q[idx_q];
      out_last_q <= (idx_q == csss_pkg::ST_FALL_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= csss_pkg::ST_SAMPLES;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= csss_pkg::ST_SAMPLES;
      end else if (adv) begin
        idx_q <= csss_pkg::stat_idx_e'(idx_q + 5'd1);
        if (idx_q == csss_pkg::ST_FALL_LAST) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy_o       = busy_q;
  assign empty_o      = !out_valid_q;
  assign stat_index_o = out_idx_q;
  assign stat_value_o = out_val_q;
  assign last_stat_o  = out_last_q;

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_q)
    else $error("snapshot loaded while a report is in flight");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_idx_q == csss_pkg::ST_FALL_LAST))
    else $error("last marker on a statistic other than the final one");

endmodule
`default_nettype wire

FILE: rtl/clock_sampled_signal_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_sampled_signal_statistics_top: sampled-signal activity monitor
// Counts and tracks a clock-sampled signal; end beats dump 19 statistics.
// ----------------------------------------------------------------------------
// Usage:
//  - Input side is a queue: a beat is taken when push is high and full low.
//    req_type 0 is a sample (value, x/z flag, timestamp), 1 ends the window.
//  - Result side is a queue: the oldest statistic sits on stat_* while empty
//    is low and is taken when pop is high. An end beat yields 19 beats,
//    stat_index 0..18, last_stat on index 18; counters clear on the end beat.
//  - Throughput: one sample per cycle while no end beat waits on a pending
//    report. The statistics engine folds samples straight from the head of a
//    4-entry queue that sits between the classifier and the engine.
//  - Order: a taken sample is written into the queue and folded into the
//    counters from its head. An end beat loads the snapshot from the queue
//    head; report beats then pass through the output register one per cycle
//    while the receiver pops. A second end beat waits in the queue until the
//    19-beat sequencer has issued the previous report, more so while the receiver stalls.
//  - Stalls: results are held in a snapshot and an output register, so a
//    stalled receiver holds the report but samples keep flowing until an
//    end beat reaches the engine while a report is still pending.
//  - Reset: counters clear, limit_enable = 1, sample_limit = 1000000,
//    signal_width = 1. Configuration writes go straight to the registers.
// ----------------------------------------------------------------------------
module clock_sampled_signal_statistics_top #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [csss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input queue
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            req_type_i,
  input  wire logic [VALUE_WIDTH-1:0]          sample_value_i,
  input  wire logic                            sample_unknown_i,
  input  wire logic [csss_pkg::TIME_W-1:0]     sample_time_i,
  // result queue
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [4:0]                           stat_index_o,
  output logic [csss_pkg::STAT_W-1:0]          stat_value_o,
  output logic                                 last_stat_o
);

  localparam int unsigned QW = $bits(csss_pkg::item_t) + VALUE_WIDTH;

  csss_pkg::cfg_t         cfg;
  logic                   wr_en;
  csss_pkg::item_t        wr_item, rd_item;
  logic [VALUE_WIDTH-1:0] wr_value, rd_value;
  logic [QW-1:0]          rd_data;
  logic                   q_empty, q_pop;
  logic                   rpt_busy, rpt_load;
  logic [csss_pkg::NUM_STATS-1:0][csss_pkg::STAT_W-1:0] stats;

  // classify and hold configuration
  csss_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push_i           (push),
    .full_i           (full),
    .req_type_i       (req_type_i),
    .sample_value_i   (sample_value_i),
    .sample_unknown_i (sample_unknown_i),
    .sample_time_i    (sample_time_i),
    .cfg_o            (cfg),
    .wr_en_o          (wr_en),
    .wr_item_o        (wr_item),
    .wr_value_o       (wr_value)
  );

  // decoupling queue
  csss_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i ({wr_item, wr_value}),
    .rd_en_i   (q_pop),
    .rd_data_o (rd_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  assign rd_item  = csss_pkg::item_t'(rd_data[QW-1:VALUE_WIDTH]);
  assign rd_value = rd_data[VALUE_WIDTH-1:0];

  // statistics engine
  csss_stats #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_item_i   (rd_item),
    .q_value_i  (rd_value),
    .q_pop_o    (q_pop),
    .rpt_busy_i (rpt_busy),
    .rpt_load_o (rpt_load),
    .stat_o     (stats)
  );

  // report sequencer and result register
  csss_report u_report (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (rpt_load),
    .stat_i       (stats),
    .busy_o       (rpt_busy),
    .pop_i        (pop),
    .empty_o      (empty),
    .stat_index_o (stat_index_o),
    .stat_value_o (stat_value_o),
    .last_stat_o  (last_stat_o)
  );

endmodule
`default_nettype wire

FILE: tb/tb_clock_sampled_signal_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_sampled_signal_statistics_top: self-checking bench for the monitor
// Drives sample and end beats through the input queue and keeps a running
// prediction of the window statistics. Every report beat is compared against
// the oldest predicted statistic. Covers directed corner cases, random
// windows under several idle/stall mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_clock_sampled_signal_statistics_top;

  localparam int          SETTLE_CYCLES = 16;     // lets queued samples drain and fold
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // one input beat as the sender sees it
  typedef struct packed {
    logic        is_end;
    logic [63:0] value;
    logic        unk;
    logic [63:0] stamp;
  } beat_t;

  // one predicted report beat
  typedef struct packed {
    csss_pkg::stat_idx_e idx;
    logic [63:0]         value;
    logic                last;
  } stat_beat_t;

  // running statistics of the open window
  typedef struct {
    logic [31:0] samples, known, unknown, trans, lows, highs, bursts, run, longest;
    logic [63:0] first_v, final_v, min_v, max_v;
    logic [63:0] chg_first, chg_last, hi_first, hi_last, fall_last;
    bit          known_seen, was_high, truncated;
  } window_stats_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = csss_pkg::CFG_LIMIT_EN;
  logic [30:0]       cfg_wdata = '0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic              req_type = 1'b0;
  logic [63:0]       smp_value = '0;
  logic              smp_unknown = 1'b0;
  logic [63:0]       smp_time = '0;
  logic              res_empty;
  logic              res_pop = 1'b0;
  logic [4:0]        stat_index;
  logic [63:0]       stat_value;
  logic              last_stat;

  // predictor state
  csss_pkg::cfg_t    cfg_model = '{limit_en: 1'b1, limit: csss_pkg::LIMIT_RESET,
                                   width: csss_pkg::WIDTH_RESET};
  window_stats_t     win = '{default: '0};
  stat_beat_t        stat_q[$];

  // stimulus knobs
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  logic              rx_hold = 1'b0;
  logic [63:0]       last_raw_value = '0;
  logic [63:0]       stamp_ps = 64'd1000;

  int unsigned       n_errors = 0;
  int unsigned       cycles = 0;

  always #5 clk = ~clk;

  clock_sampled_signal_statistics_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .push             (in_push),
    .full             (in_full),
    .req_type_i       (req_type),
    .sample_value_i   (smp_value),
    .sample_unknown_i (smp_unknown),
    .sample_time_i    (smp_time),
    .empty            (res_empty),
    .pop              (res_pop),
    .stat_index_o     (stat_index),
    .stat_value_o     (stat_value),
    .last_stat_o      (last_stat)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // counters stick at all-ones
  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  // width register as the block applies it: 0 -> 1, above 64 -> 64
  function automatic int eff_width();
    if (cfg_model.width == 0) return 1;
    if (cfg_model.width > 64) return 64;
    return int'(cfg_model.width);
  endfunction

  function automatic logic [63:0] width_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic void close_run(logic [63:0] stamp);
    if (win.run > win.longest) win.longest = win.run;
    win.run       = '0;
    win.fall_last = stamp;
    win.was_high  = 1'b0;
  endfunction

  function automatic void fold_sample(logic [63:0] value, logic unk, logic [63:0] stamp);
    int          w;
    logic [63:0] v;
    bit          high;
    if (win.truncated) return;
    win.samples = bump(win.samples);
    // limit check happens after counting, so the offending sample is counted
    if (cfg_model.limit_en && win.samples > {1'b0, cfg_model.limit}) begin
      win.truncated = 1'b1;
      return;
    end
    if (unk) begin
      win.unknown = bump(win.unknown);
      if (win.was_high) close_run(stamp);
      return;
    end
    w = eff_width();
    v = value & width_mask(w);
    win.known = bump(win.known);
    high = (v != 0) && (w == 1);
    if (v == 0) win.lows = bump(win.lows);
    else if (high) win.highs = bump(win.highs);
    if (high) begin
      if (!win.was_high) begin
        win.bursts = bump(win.bursts);
        win.run    = '0;
        // a first high at time zero leaves the slot empty
        if (win.hi_first == 0) win.hi_first = stamp;
      end
      win.run      = bump(win.run);
      win.hi_last  = stamp;
      win.was_high = 1'b1;
    end else if (win.was_high) begin
      close_run(stamp);
    end
    if (!win.known_seen) begin
      win.first_v    = v;
      win.final_v    = v;
      win.min_v      = v;
      win.max_v      = v;
      win.known_seen = 1'b1;
    end else begin
      if (v != win.final_v) begin
        win.trans = bump(win.trans);
        if (win.chg_first == 0) win.chg_first = stamp;
        win.chg_last = stamp;
      end
      if (v < win.min_v) win.min_v = v;
      if (v > win.max_v) win.max_v = v;
      win.final_v = v;
    end
  endfunction

  // end beat: fold the open run, queue the 19 statistics, clear the window
  function automatic void publish_report();
    logic [63:0] vals[csss_pkg::NUM_STATS];
    stat_beat_t  e;
    if (win.was_high && win.run > win.longest) win.longest = win.run;
    vals[csss_pkg::ST_SAMPLES]     = 64'(win.samples);
    vals[csss_pkg::ST_KNOWN]       = 64'(win.known);
    vals[csss_pkg::ST_UNKNOWN]     = 64'(win.unknown);
    vals[csss_pkg::ST_TRANSITIONS] = 64'(win.trans);
    vals[csss_pkg::ST_TRUNCATED]   = 64'(win.truncated);
    vals[csss_pkg::ST_KNOWN_SEEN]  = 64'(win.known_seen);
    vals[csss_pkg::ST_FIRST]       = win.first_v;
    vals[csss_pkg::ST_FINAL]       = win.final_v;
    vals[csss_pkg::ST_MIN]         = win.min_v;
    vals[csss_pkg::ST_MAX]         = win.max_v;
    vals[csss_pkg::ST_LOW]         = 64'(win.lows);
    vals[csss_pkg::ST_HIGH]        = 64'(win.highs);
    vals[csss_pkg::ST_BURSTS]      = 64'(win.bursts);
    vals[csss_pkg::ST_MAX_RUN]     = 64'(win.longest);
    vals[csss_pkg::ST_CHG_FIRST]   = win.chg_first;
    vals[csss_pkg::ST_CHG_LAST]    = win.chg_last;
    vals[csss_pkg::ST_HIGH_FIRST]  = win.hi_first;
    vals[csss_pkg::ST_HIGH_LAST]   = win.hi_last;
    vals[csss_pkg::ST_FALL_LAST]   = win.fall_last;
    for (int k = 0; k < csss_pkg::NUM_STATS; k++) begin
      e.idx   = csss_pkg::stat_idx_e'(k);
      e.value = vals[k];
      e.last  = (k == csss_pkg::NUM_STATS - 1);
      stat_q  = {stat_q, e};
    end
    win = '{default: '0};
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check every popped beat, then pick pop for the next edge
  // --------------------------------------------------------------------------
  function automatic void check_stat_beat();
    stat_beat_t want;
    if (stat_q.size() == 0) begin
      $error("stat beat with nothing pending: index %0d value %0h", stat_index, stat_value);
      n_errors++;
      return;
    end
    want = stat_q.pop_front();
    if (stat_index !== want.idx) begin
      $error("stat_index: expected %0d, actual %0d", want.idx, stat_index);
      n_errors++;
    end
    if (stat_value !== want.value) begin
      $error("stat_value (%s): expected %0h, actual %0h", want.idx.name(), want.value,
             stat_value);
      n_errors++;
    end
    if (last_stat !== want.last) begin
      $error("last_stat (%s): expected %0b, actual %0b", want.idx.name(), want.last,
             last_stat);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && res_pop && !res_empty) check_stat_beat();
    res_pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("clock_sampled_signal_statistics_top: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // push stays high across back-to-back beats; it only drops in an idle gap
  // or when a caller parks the sender
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push     <= 1'b1;
    req_type    <= b.is_end;
    smp_value   <= b.value;
    smp_unknown <= b.unk;
    smp_time    <= b.stamp;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (b.is_end) publish_report();
    else fold_sample(b.value, b.unk, b.stamp);
  endtask

  task automatic send_sample(logic [63:0] value, logic unk, logic [63:0] stamp);
    send_beat('{is_end: 1'b0, value: value, unk: unk, stamp: stamp});
  endtask

  // end beat; its payload fields are don't-care, so fill them with noise
  task automatic send_end();
    send_beat('{is_end: 1'b1, value: {$urandom, $urandom}, unk: 1'($urandom),
                stamp: {$urandom, $urandom}});
  endtask

  // park the sender until every predicted beat is out, then let queued
  // samples (which produce nothing) finish folding
  task automatic settle();
    in_push <= 1'b0;
    while (stat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      csss_pkg::CFG_LIMIT_EN: cfg_model.limit_en = data[0];
      csss_pkg::CFG_LIMIT:    cfg_model.limit    = data;
      csss_pkg::CFG_WIDTH:    cfg_model.width    = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(bit en, logic [30:0] lim, logic [6:0] w);
    settle();
    write_reg(csss_pkg::CFG_LIMIT_EN, 31'(en));
    write_reg(csss_pkg::CFG_LIMIT, lim);
    write_reg(csss_pkg::CFG_WIDTH, 31'(w));
    cfg_we <= 1'b0;
  endtask

  // random sample: a share of values vanish under the width mask, a share
  // repeat so runs and non-transitions show up; timestamps mostly climb
  function automatic beat_t make_sample();
    beat_t       b;
    int unsigned r;
    b.is_end = 1'b0;
    b.unk    = ($urandom_range(99) < 12);
    b.value  = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r < 3) b.value = b.value & ~width_mask(eff_width());
    else if (r < 5) b.value = last_raw_value;
    last_raw_value = b.value;
    stamp_ps += 64'($urandom_range(1, 5000));
    r = $urandom_range(19);
    if (r == 0) b.stamp = '0;
    else if (r == 1) b.stamp = {$urandom, $urandom};
    else b.stamp = stamp_ps;
    return b;
  endfunction

  // windows of 0..12 samples, most closed by an end beat
  task automatic run_windows(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        send_beat(make_sample());
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_end();
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset config (width 1): empty report, time-zero slots, x/z ending a run,
  // masking of upper bits, run left open at the end beat
  task automatic test_window_basics();
    send_end();
    send_sample(64'd1, 1'b0, 64'd0);       // first high at time 0 keeps slot empty
    send_sample(64'd1, 1'b0, 64'd10);
    send_sample('1, 1'b1, 64'd20);         // x/z closes the high run
    send_sample(64'd0, 1'b0, 64'd0);       // first change at time 0
    send_sample('1, 1'b0, 64'd30);         // masked to 1
    send_sample(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '1);
    send_sample(64'd1, 1'b0, 64'd40);
    send_end();                            // open run folded here
  endtask

  // full width: wide nonzero values are neither low nor high; width 0 acts as 1
  task automatic test_width_handling();
    set_config(1'b1, '1, 7'd64);
    send_sample('1, 1'b0, 64'd5);
    send_sample(64'd0, 1'b0, 64'd6);
    send_sample(64'h8000_0000_0000_0000, 1'b0, '1);
    send_sample(64'h1234, 1'b1, 64'd8);
    send_end();
    set_config(1'b1, csss_pkg::LIMIT_RESET, 7'd0);
    send_sample(64'd2, 1'b0, 64'd5);
    send_sample(64'd3, 1'b0, 64'd6);
    send_end();
  endtask

  task automatic test_truncation();
    set_config(1'b1, 31'd2, 7'd1);
    send_sample(64'd1, 1'b0, 64'd1);
    send_sample(64'd0, 1'b0, 64'd2);
    send_sample(64'd1, 1'b0, 64'd3);      // over the limit: flags truncation
    send_sample(64'd1, 1'b0, 64'd4);      // ignored
    send_end();
    // limit off: a zero limit has no effect
    set_config(1'b0, 31'd0, 7'd1);
    send_sample(64'd1, 1'b0, 64'd7);
    send_sample(64'd0, 1'b0, 64'd8);
    send_end();
  endtask

  // four idle mixes, two register settings each
  task automatic test_random_traffic();
    bit          en_tab[8]  = '{1, 1, 1, 0, 1, 1, 0, 1};
    logic [30:0] lim_tab[8] = '{31'd1000000, '1, 31'd7, 31'd0, 31'd0, 31'd20, 31'd3,
                                31'd11};
    logic [6:0]  w_tab[8]   = '{7'd1, 7'd0, 7'd1, 7'd64, 7'd1, 7'd127, 7'd2, 7'd8};
    int unsigned tx_tab[4]  = '{0, 47, 0, 28};
    int unsigned rx_tab[4]  = '{0, 0, 47, 28};
    for (int ph = 0; ph < 4; ph++) begin
      for (int h = 0; h < 2; h++) begin
        set_config(en_tab[2*ph+h], lim_tab[2*ph+h], w_tab[2*ph+h]);
        tx_idle_pct  = tx_tab[ph];
        rx_stall_pct = rx_tab[ph];
        run_windows(10);
      end
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // receiver holds off long enough that pending reports back up into the
  // input queue and full asserts; the sender keeps offering meanwhile
  task automatic test_backpressure();
    set_config(1'b1, csss_pkg::LIMIT_RESET, 7'd1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (int n = 0; n < 3; n++) begin
      for (int k = 0; k < 5; k++) send_beat(make_sample());
      send_end();
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_basics();
    test_width_handling();
    test_truncation();
    test_random_traffic();
    test_backpressure();
    settle();
    if (n_errors == 0 && stat_q.size() == 0) begin
      $display("clock_sampled_signal_statistics_top: match");
    end else begin
      $display("clock_sampled_signal_statistics_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/csss_pkg.sv
rtl/csss_front.sv
rtl/csss_queue.sv
rtl/csss_stats.sv
rtl/csss_report.sv
rtl/clock_sampled_signal_statistics_top.sv
tb/tb_clock_sampled_signal_statistics_top.sv
